// ----- sv/spc_pkg.sv -----
`timescale 1ns / 1ps

package spc_pkg;

    localparam int SPC_STAGES = 5;

    localparam logic [16:0] MIX_ONE = 17'd65536;
    localparam logic [16:0] FULL_SQ = 17'd65025;
    localparam logic signed [35:0] HALF_DENOM = 36'sd8355840;
    localparam logic [15:0] RECIP_255 = 16'd32897;

    typedef enum logic [3:0] {
        MODE_IN_FRONT   = 4'd0,
        MODE_BEHIND     = 4'd1,
        MODE_ADD        = 4'd2,
        MODE_MULTIPLY   = 4'd3,
        MODE_SCREEN     = 4'd4,
        MODE_OVERLAY    = 4'd5,
        MODE_HARD_LIGHT = 4'd6,
        MODE_SOFT_LIGHT = 4'd7,
        MODE_DIFFERENCE = 4'd8,
        MODE_STENCIL    = 4'd9,
        MODE_SILHOUETTE = 4'd10
    } layer_mode_t;

    typedef enum logic [1:0] {
        CFG_LAYER_MODE  = 2'd0,
        CFG_MIX_AMOUNT  = 2'd1,
        CFG_COLOUR_ONLY = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        TGT_IDENT,
        TGT_ADD,
        TGT_MUL,
        TGT_SCREEN,
        TGT_OVERLAY,
        TGT_ZERO,
        TGT_SILH
    } target_kind_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } pixel_out_t;

    typedef struct packed {
        logic [SPC_STAGES-1:0] en;
    } pipe_ctl_t;

endpackage

// ----- sv/spc_pipe_ctrl.sv -----
`timescale 1ns / 1ps

module spc_pipe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output spc_pkg::pipe_ctl_t ctl
);
    import spc_pkg::*;

    logic [SPC_STAGES-1:0] valid_reg;
    logic [SPC_STAGES-1:0] valid_next;
    logic [SPC_STAGES-1:0] en;

    // advance a stage when it is empty or its successor advances
    always_comb
    begin
        en[SPC_STAGES-1] = !valid_reg[SPC_STAGES-1] || out_ready;
        for (int k = SPC_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < SPC_STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[SPC_STAGES-1];
    assign ctl.en    = en;

endmodule

// ----- sv/spc_lane.sv -----
`timescale 1ns / 1ps

module spc_lane (
    input  logic                 clk,
    input  spc_pkg::pipe_ctl_t   ctl,
    input  spc_pkg::target_kind_t kind,
    input  logic [16:0]          mix,
    input  logic [7:0]           chan_in,
    output logic [7:0]           chan_out
);
    import spc_pkg::*;

    logic [7:0]          inv1;
    logic [7:0]          mul_a;
    logic [7:0]          mul_b;
    logic [15:0]         prod1_next;
    logic [15:0]         prod1_reg;
    logic [7:0]          c1_reg;
    target_kind_t        kind1_reg;

    logic [15:0]         base2;
    logic [7:0]          add_sat2;
    logic [15:0]         add_tgt2;
    logic [16:0]         tgt2;
    logic signed [17:0]  d2_next;
    logic signed [17:0]  d2_reg;
    logic [7:0]          c2_reg;

    logic signed [35:0]  p3_next;
    logic signed [35:0]  p3_reg;
    logic [7:0]          c3_reg;

    logic [15:0]         base4;
    logic signed [35:0]  num4;
    logic [15:0]         q4_next;
    logic [15:0]         q4_reg;

    logic [31:0]         prod5;
    logic [7:0]          out5_next;
    logic [7:0]          out5_reg;

    // stage 1: square or c*(255-c) term of the blend target
    always_comb
    begin
        inv1 = 8'hFF - chan_in;
        mul_a = chan_in;
        mul_b = chan_in;
        case (kind)
            TGT_SCREEN:
            begin
                mul_a = inv1;
                mul_b = inv1;
            end
            TGT_OVERLAY:
            begin
                if (chan_in[7])
                begin
                    mul_a = inv1;
                    mul_b = inv1;
                end
            end
            TGT_SILH:
            begin
                mul_b = inv1;
            end
            default:
            begin
                mul_a = chan_in;
                mul_b = chan_in;
            end
        endcase
        prod1_next = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            prod1_reg <= prod1_next;
            c1_reg    <= chan_in;
            kind1_reg <= kind;
        end
    end

    // stage 2: target in units of 1/255, minus 255c
    always_comb
    begin
        base2    = {c1_reg, 8'd0} - {8'd0, c1_reg};
        add_sat2 = c1_reg[7] ? 8'hFF : {c1_reg[6:0], 1'b0};
        add_tgt2 = {add_sat2, 8'd0} - {8'd0, add_sat2};
        case (kind1_reg)
            TGT_ADD:     tgt2 = {1'b0, add_tgt2};
            TGT_MUL:     tgt2 = {1'b0, prod1_reg};
            TGT_SILH:    tgt2 = {1'b0, prod1_reg};
            TGT_SCREEN:  tgt2 = FULL_SQ - {1'b0, prod1_reg};
            TGT_OVERLAY: tgt2 = c1_reg[7] ? FULL_SQ - {prod1_reg, 1'b0}
                                          : {prod1_reg, 1'b0};
            TGT_ZERO:    tgt2 = '0;
            default:     tgt2 = {1'b0, base2};
        endcase
        d2_next = $signed({1'b0, tgt2}) - $signed({2'b0, base2});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            d2_reg <= d2_next;
            c2_reg <= c1_reg;
        end
    end

    // stage 3: scale by mix
    assign p3_next = d2_reg * $signed({1'b0, mix});

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            p3_reg <= p3_next;
            c3_reg <= c2_reg;
        end
    end

    // stage 4: add back 255c, round, drop the Q0.16 fraction
    assign base4   = {c3_reg, 8'd0} - {8'd0, c3_reg};
    assign num4    = $signed({4'd0, base4, 16'd0}) + p3_reg + HALF_DENOM;
    assign q4_next = num4[31:16];

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            q4_reg <= q4_next;
        end
    end

    // stage 5: divide by 255 through the reciprocal
    assign prod5     = q4_reg * RECIP_255;
    assign out5_next = prod5[30:23];

    always_ff @(posedge clk)
    begin
        if (ctl.en[4])
        begin
            out5_reg <= out5_next;
        end
    end

    assign chan_out = out5_reg;

endmodule

// ----- sv/self_blend_pixel_compositor.sv -----
`timescale 1ns / 1ps
// Throughput: one beat per cycle unless out_ready stalls the pipe;
// five register stages per channel (square, target, mix multiply,
// round, divide by 255).
// Reset: asynchronous active-low; clears stage valid bits and sets
// the layer mode to in-front, mix_amount to full, colour_only off.

module self_blend_pixel_compositor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spc_pkg::pixel_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output spc_pkg::pixel_out_t out_data,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [16:0]         wr_data
);
    import spc_pkg::*;

    logic [3:0]   layer_mode_reg;
    logic [16:0]  mix_amount_reg;
    logic         colour_only_reg;

    layer_mode_t  mode_eff;
    logic [16:0]  mix_eff;
    logic [16:0]  mix_alpha;
    target_kind_t colour_kind;
    target_kind_t alpha_kind;
    pipe_ctl_t    ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_mode_reg  <= MODE_IN_FRONT;
            mix_amount_reg  <= MIX_ONE;
            colour_only_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_LAYER_MODE:  layer_mode_reg  <= wr_data[3:0];
                CFG_MIX_AMOUNT:  mix_amount_reg  <= wr_data;
                CFG_COLOUR_ONLY: colour_only_reg <= wr_data[0];
                default:         ;
            endcase
        end
    end

    // saturate mode and mix
    always_comb
    begin
        if (layer_mode_reg > MODE_SILHOUETTE)
        begin
            mode_eff = MODE_SILHOUETTE;
        end
        else
        begin
            mode_eff = layer_mode_t'(layer_mode_reg);
        end
        mix_eff   = (mix_amount_reg > MIX_ONE) ? MIX_ONE : mix_amount_reg;
        mix_alpha = colour_only_reg ? '0 : mix_eff;
    end

    always_comb
    begin
        case (mode_eff)
            MODE_ADD:        colour_kind = TGT_ADD;
            MODE_MULTIPLY:   colour_kind = TGT_MUL;
            MODE_SCREEN:     colour_kind = TGT_SCREEN;
            MODE_OVERLAY:    colour_kind = TGT_OVERLAY;
            MODE_DIFFERENCE: colour_kind = TGT_ZERO;
            default:         colour_kind = TGT_IDENT;
        endcase
        case (mode_eff)
            MODE_STENCIL:    alpha_kind = TGT_MUL;
            MODE_SILHOUETTE: alpha_kind = TGT_SILH;
            default:         alpha_kind = TGT_IDENT;
        endcase
    end

    spc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    spc_lane u_red (
        .clk      (clk),
        .ctl      (ctl),
        .kind     (colour_kind),
        .mix      (mix_eff),
        .chan_in  (in_data.red_in),
        .chan_out (out_data.red_out)
    );

    spc_lane u_green (
        .clk      (clk),
        .ctl      (ctl),
        .kind     (colour_kind),
        .mix      (mix_eff),
        .chan_in  (in_data.green_in),
        .chan_out (out_data.green_out)
    );

    spc_lane u_blue (
        .clk      (clk),
        .ctl      (ctl),
        .kind     (colour_kind),
        .mix      (mix_eff),
        .chan_in  (in_data.blue_in),
        .chan_out (out_data.blue_out)
    );

    spc_lane u_alpha (
        .clk      (clk),
        .ctl      (ctl),
        .kind     (alpha_kind),
        .mix      (mix_alpha),
        .chan_in  (in_data.alpha_in),
        .chan_out (out_data.alpha_out)
    );

endmodule

// ----- tb/self_blend_pixel_compositor_tb.sv -----
`timescale 1ns / 1ps

module self_blend_pixel_compositor_tb;

    import spc_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam longint MIX_SCALE = 64'd255 * 64'd65536;
    localparam longint MIX_FULL = 64'd65536;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    pixel_in_t  in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    pixel_out_t out_data;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = CFG_LAYER_MODE;
    logic [16:0] wr_data = '0;

    logic [3:0]  cur_mode = MODE_IN_FRONT;
    logic [16:0] cur_mix = MIX_ONE;
    logic        cur_colour_only = 1'b0;

    pixel_in_t  pixel_backlog[$];
    pixel_out_t expected_pixels[$];
    int         mismatches = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_run = 0;
    bit         ready_phase = 1'b0;

    self_blend_pixel_compositor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint colour_goal(layer_mode_t mode, longint c);
        longint inv;
        inv = 255 - c;
        case (mode)
            MODE_ADD:        colour_goal = 255 * ((2 * c > 255) ? 255 : 2 * c);
            MODE_MULTIPLY:   colour_goal = c * c;
            MODE_SCREEN:     colour_goal = 255 * 255 - inv * inv;
            MODE_OVERLAY:    colour_goal = (c < 128) ? 2 * c * c : 255 * 255 - 2 * inv * inv;
            MODE_DIFFERENCE: colour_goal = 0;
            default:         colour_goal = 255 * c;
        endcase
    endfunction

    // goal is the blend target scaled by 255; round half up after clamping
    function automatic logic [7:0] mix_toward(longint c, longint goal, longint m);
        longint num;
        num = c * MIX_SCALE + (goal - 255 * c) * m;
        if (num < 0)
            num = 0;
        if (num > 255 * MIX_SCALE)
            num = 255 * MIX_SCALE;
        mix_toward = 8'((num + MIX_SCALE / 2) / MIX_SCALE);
    endfunction

    function automatic pixel_out_t composite_pixel(pixel_in_t px);
        layer_mode_t mode;
        longint      m;
        longint      r;
        longint      g;
        longint      b;
        longint      a;
        longint      alpha_goal;
        pixel_out_t  res;
        mode = (cur_mode > MODE_SILHOUETTE) ? MODE_SILHOUETTE : layer_mode_t'(cur_mode);
        m = (cur_mix > MIX_ONE) ? MIX_FULL : longint'(cur_mix);
        r = longint'(px.red_in);
        g = longint'(px.green_in);
        b = longint'(px.blue_in);
        a = longint'(px.alpha_in);
        res.red_out = mix_toward(r, colour_goal(mode, r), m);
        res.green_out = mix_toward(g, colour_goal(mode, g), m);
        res.blue_out = mix_toward(b, colour_goal(mode, b), m);
        case (mode)
            MODE_STENCIL:    alpha_goal = a * a;
            MODE_SILHOUETTE: alpha_goal = a * (255 - a);
            default:         alpha_goal = 255 * a;
        endcase
        res.alpha_out = cur_colour_only ? px.alpha_in : mix_toward(a, alpha_goal, m);
        composite_pixel = res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_pixels.push_back(composite_pixel(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pixel_backlog.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_run > 0)
                stall_run--;
            else
            begin
                ready_phase = !ready_phase;
                stall_run = ready_phase ? $urandom_range(0, 24) : $urandom_range(0, 7);
            end
            out_ready <= ready_phase;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: beat expected none actual %h", $time, out_data);
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("red_out", want.red_out, out_data.red_out);
                check_field("green_out", want.green_out, out_data.green_out);
                check_field("blue_out", want.blue_out, out_data.blue_out);
                check_field("alpha_out", want.alpha_out, out_data.alpha_out);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        case (idx)
            CFG_LAYER_MODE:  cur_mode = value[3:0];
            CFG_MIX_AMOUNT:  cur_mix = value;
            CFG_COLOUR_ONLY: cur_colour_only = value[0];
            default:         ;
        endcase
    endtask

    task automatic apply_settings(input logic [3:0] mode, input logic [16:0] mix,
                                  input logic colour_only, input bit poke_unused);
        logic [16:0] junk;
        junk = 17'($urandom());
        write_reg(CFG_LAYER_MODE, {junk[16:4], mode});
        write_reg(CFG_MIX_AMOUNT, mix);
        junk = 17'($urandom());
        write_reg(CFG_COLOUR_ONLY, {junk[16:1], colour_only});
        if (poke_unused)
            write_reg(CFG_UNUSED, 17'($urandom()));
        @(posedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pixel_backlog.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    function automatic pixel_in_t random_pixel();
        logic [7:0] corner_vals[6];
        pixel_in_t  px;
        corner_vals = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        px = $urandom();
        if ($urandom_range(0, 3) == 0)
        begin
            px.red_in = corner_vals[$urandom_range(0, 5)];
            px.green_in = corner_vals[$urandom_range(0, 5)];
            px.blue_in = corner_vals[$urandom_range(0, 5)];
            px.alpha_in = corner_vals[$urandom_range(0, 5)];
        end
        random_pixel = px;
    endfunction

    initial
    begin
        pixel_in_t   corners[8];
        logic [16:0] mix_picks[7];
        logic [16:0] mix;
        int          count;
        corners = '{32'h00000000, 32'hFFFFFFFF, 32'h7F7F7F7F, 32'h80808080,
                    32'h01FE40C0, 32'hFE01C040, 32'hAA55AA55, 32'h55AA55AA};
        mix_picks = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'd65537,
                      17'd131071};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings first
        pixel_backlog.push_back(corners[1]);
        pixel_backlog.push_back(corners[4]);
        wait_drained();

        for (int mode = 0; mode < 16; mode++)
        begin
            apply_settings(4'(mode), MIX_ONE, 1'b0, mode == 3);
            pixel_backlog.push_back(corners[(2 * mode) % 8]);
            pixel_backlog.push_back(corners[(2 * mode + 1) % 8]);
            wait_drained();
        end

        for (int phase = 0; phase < 26; phase++)
        begin
            if (phase < 7)
                mix = mix_picks[phase];
            else if (phase % 2 == 1)
                mix = 17'($urandom_range(0, MIX_FULL));
            else
                mix = 17'($urandom_range(0, 131071));
            apply_settings(4'((phase < 16) ? (phase * 5) % 16 : $urandom_range(0, 15)),
                           mix, (phase % 3 == 2), ($urandom_range(0, 3) == 0));
            count = $urandom_range(20, 30);
            repeat (count)
                pixel_backlog.push_back(random_pixel());
            wait_drained();
        end

        repeat (SPC_STAGES + 5) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- self_blend_pixel_compositor.f -----
sv/spc_pkg.sv
sv/spc_pipe_ctrl.sv
sv/spc_lane.sv
sv/self_blend_pixel_compositor.sv
tb/self_blend_pixel_compositor_tb.sv
